[hw/rtl/histogram_matching_unit_assert.svh]
// Assertion macros used by histogram_matching_unit.sv.
`ifndef HISTOGRAM_MATCHING_UNIT_ASSERT_SVH
`define HISTOGRAM_MATCHING_UNIT_ASSERT_SVH

// Same-cycle implication.
`define HMU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HMU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/hmu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hmu_pkg;

   localparam int LEVELS_DEF      = 256;
   localparam int COUNT_BITS_DEF  = 22;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int MODE_BITS         = 2;
   localparam int LEVEL_BITS        = 8;
   localparam int WEIGHT_FIELD_BITS = 16;
   localparam int OUT_LEVEL_BITS    = 8;

   localparam logic [MODE_BITS-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_COUNT = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_BUILD = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_MAP   = 2'd3;

   typedef struct packed {
      logic cnt_we;
      logic cnt_clr;
      logic wt_we;
   } store_cmd_type;

endpackage

`default_nettype wire

[hw/rtl/histogram_matching_unit.sv]
// Load items are written from idle, count items pass S_CNT, and map results go from map_q_ff
// to the response register, waiting in S_MAP while it is full. A build sums target weights,
// then per source level advances the target level via the single shared multiplier.
// Input is taken only in idle; one item at a time, the result register frees the input side.
// Synchronous active-high reset clears counts, weights, pixel total and the map-valid flag.
// The level map is undefined until the first build.
`timescale 1ns / 1ps
`default_nettype none
`include "histogram_matching_unit_assert.svh"

module histogram_matching_unit #(
   parameter int LEVELS      = hmu_pkg::LEVELS_DEF,
   parameter int COUNT_BITS  = hmu_pkg::COUNT_BITS_DEF,
   parameter int WEIGHT_BITS = hmu_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // level [7:0], weight [23:8]
   input  wire logic [1:0]  req_tuser,   // mode [1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // mapped_level [7:0]
   output logic      [0:0]  rsp_tuser    // build_done [0]
);

   localparam int AW    = $clog2(LEVELS);
   localparam int TOT_W = WEIGHT_BITS + AW;
   localparam int PRD_W = TOT_W + COUNT_BITS;
   localparam logic [AW-1:0] LAST = AW'(LEVELS - 1);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_CNT  = 11'b000_0000_0010,
      S_MAP  = 11'b000_0000_0100,
      S_SUM  = 11'b000_0000_1000,
      S_SRC  = 11'b000_0001_0000,
      S_MULA = 11'b000_0010_0000,
      S_MULB = 11'b000_0100_0000,
      S_CMP  = 11'b000_1000_0000,
      S_WADV = 11'b001_0000_0000,
      S_EMIT = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [hmu_pkg::MODE_BITS-1:0]         req_mode;
   logic [hmu_pkg::LEVEL_BITS-1:0]        req_level;
   logic [hmu_pkg::WEIGHT_FIELD_BITS-1:0] req_weight;
   logic                                  req_xfer;
   logic                                  req_in_range;
   logic [AW-1:0]                         req_lvl_idx;
   logic [AW-1:0]                         req_map_idx;
   logic                                  rsp_free;

   logic [AW-1:0]          i_ff, i_in;
   logic [AW-1:0]          j_ff, j_in;
   logic [AW-1:0]          lvl_ff, lvl_in;
   logic [COUNT_BITS-1:0]  pix_total_ff, pix_total_in;
   logic [TOT_W-1:0]       wt_total_ff, wt_total_in;
   logic [TOT_W-1:0]       wt_cum_ff, wt_cum_in;
   logic [COUNT_BITS-1:0]  src_cum_ff, src_cum_in;
   logic [PRD_W-1:0]       lhs_ff, lhs_in;
   logic                   map_valid_ff, map_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [hmu_pkg::OUT_LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic [hmu_pkg::OUT_LEVEL_BITS-1:0] map_q_ff;
   logic [hmu_pkg::OUT_LEVEL_BITS-1:0] map_mem [LEVELS];
   logic                   map_we;

   hmu_pkg::store_cmd_type cmd;
   logic [AW-1:0]          cnt_addr;
   logic [COUNT_BITS-1:0]  cnt_wdata;
   logic [COUNT_BITS-1:0]  cnt_rd;
   logic [AW-1:0]          wt_addr;
   logic [WEIGHT_BITS-1:0] wt_wdata;
   logic [WEIGHT_BITS-1:0] wt_rd;

   logic [TOT_W-1:0]       mul_a;
   logic [COUNT_BITS-1:0]  mul_b;
   logic [PRD_W-1:0]       mul_prod;
   logic [COUNT_BITS:0]    src_sum;

   assign req_level    = req_tdata[7:0];
   assign req_weight   = req_tdata[23:8];
   assign req_mode     = req_tuser;
   assign req_tready   = (state_ff == S_IDLE);
   assign req_xfer     = req_tvalid && req_tready;
   assign req_in_range = {1'b0, req_level} < 9'(LEVELS);
   assign req_lvl_idx  = req_level[AW-1:0];
   assign req_map_idx  = req_in_range ? req_lvl_idx : LAST;
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign wt_wdata     = WEIGHT_BITS'(req_weight);
   assign src_sum      = {1'b0, src_cum_ff} + {1'b0, cnt_rd};

   assign mul_a = (state_ff == S_MULA) ? wt_cum_ff : wt_total_ff;
   assign mul_b = (state_ff == S_MULA) ? pix_total_ff : src_cum_ff;

   hmu_store #(
      .LEVELS      (LEVELS),
      .COUNT_BITS  (COUNT_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cnt_addr  (cnt_addr),
      .cnt_wdata (cnt_wdata),
      .cnt_rdata (cnt_rd),
      .wt_addr   (wt_addr),
      .wt_wdata  (wt_wdata),
      .wt_rdata  (wt_rd)
   );

   hmu_mul #(
      .A_BITS (TOT_W),
      .B_BITS (COUNT_BITS)
   ) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lvl_in       = lvl_ff;
      pix_total_in = pix_total_ff;
      wt_total_in  = wt_total_ff;
      wt_cum_in    = wt_cum_ff;
      src_cum_in   = src_cum_ff;
      lhs_in       = lhs_ff;
      map_valid_in = map_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_level_in = rsp_level_ff;
      rsp_done_in  = rsp_done_ff;
      cmd          = '0;
      cnt_addr     = i_ff;
      cnt_wdata    = cnt_rd;
      wt_addr      = j_ff;
      map_we       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cnt_addr = req_lvl_idx;
            wt_addr  = (req_mode == hmu_pkg::MODE_BUILD) ? '0 : req_lvl_idx;
            if (req_xfer) begin
               lvl_in = req_lvl_idx;
               unique case (req_mode)
                  hmu_pkg::MODE_LOAD: begin
                     cmd.wt_we = req_in_range;
                  end
                  hmu_pkg::MODE_COUNT: begin
                     if (req_in_range) begin
                        state_in = S_CNT;
                     end
                  end
                  hmu_pkg::MODE_BUILD: begin
                     wt_total_in = '0;
                     src_cum_in  = '0;
                     i_in        = '0;
                     j_in        = '0;
                     state_in    = S_SUM;
                  end
                  hmu_pkg::MODE_MAP: begin
                     if (map_valid_ff) begin
                        state_in = S_MAP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CNT: begin
            cnt_addr   = lvl_ff;
            cmd.cnt_we = 1'b1;
            if (cnt_rd != '1) begin
               cnt_wdata = cnt_rd + COUNT_BITS'(1);
            end
            if (pix_total_ff != '1) begin
               pix_total_in = pix_total_ff + COUNT_BITS'(1);
            end
            state_in = S_IDLE;
         end
         S_MAP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = map_q_ff;
               rsp_done_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_SUM: begin
            wt_total_in = wt_total_ff + TOT_W'(wt_rd);
            if (i_ff == LAST) begin
               i_in     = '0;
               wt_addr  = '0;
               cnt_addr = '0;
               state_in = S_SRC;
            end else begin
               i_in    = i_ff + AW'(1);
               wt_addr = i_ff + AW'(1);
            end
         end
         S_SRC: begin
            src_cum_in = (src_sum > {1'b0, pix_total_ff}) ? pix_total_ff
                                                          : src_sum[COUNT_BITS-1:0];
            if (i_ff == '0) begin
               wt_cum_in = TOT_W'(wt_rd);
            end
            state_in = S_MULA;
         end
         S_MULA: begin
            state_in = (j_ff == LAST) ? S_EMIT : S_MULB;
         end
         S_MULB: begin
            lhs_in   = mul_prod;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (lhs_ff < mul_prod) begin
               j_in     = j_ff + AW'(1);
               wt_addr  = j_ff + AW'(1);
               state_in = S_WADV;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_WADV: begin
            wt_cum_in = wt_cum_ff + TOT_W'(wt_rd);
            state_in  = S_MULA;
         end
         S_EMIT: begin
            map_we = 1'b1;
            if (i_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               i_in     = i_ff + AW'(1);
               cnt_addr = i_ff + AW'(1);
               state_in = S_SRC;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = '0;
               rsp_done_in  = 1'b1;
               cmd.cnt_clr  = 1'b1;
               pix_total_in = '0;
               map_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pix_total_ff <= '0;
         map_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pix_total_ff <= pix_total_in;
         map_valid_ff <= map_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      lvl_ff       <= lvl_in;
      wt_total_ff  <= wt_total_in;
      wt_cum_ff    <= wt_cum_in;
      src_cum_ff   <= src_cum_in;
      lhs_ff       <= lhs_in;
      rsp_level_ff <= rsp_level_in;
      rsp_done_ff  <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[i_ff] <= hmu_pkg::OUT_LEVEL_BITS'(j_ff);
      end
      if (req_xfer) begin
         map_q_ff <= map_mem[req_map_idx];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tuser  = rsp_done_ff;

   `HMU_ASSERT_SAME(a_map_needs_build, clock, reset, state_ff == S_MAP, map_valid_ff, "map read without a built map")
   `HMU_ASSERT_SAME(a_share_bounds, clock, reset, state_ff == S_MULA, (src_cum_ff <= pix_total_ff) && (wt_cum_ff <= wt_total_ff), "cumulative sum exceeds its total")
   `HMU_ASSERT_SAME(a_cmp_not_last, clock, reset, state_ff == S_CMP, j_ff != LAST, "compare past last target level")
   `HMU_ASSERT_NEXT(a_build_clears, clock, reset, (state_ff == S_DONE) && rsp_free, (pix_total_ff == '0) && map_valid_ff && rsp_tvalid && rsp_done_ff, "build end did not clear and report")

endmodule

`default_nettype wire

[hw/rtl/hmu_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module hmu_store #(
   parameter int LEVELS      = hmu_pkg::LEVELS_DEF,
   parameter int COUNT_BITS  = hmu_pkg::COUNT_BITS_DEF,
   parameter int WEIGHT_BITS = hmu_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire hmu_pkg::store_cmd_type      cmd,
   input  wire logic [$clog2(LEVELS)-1:0]   cnt_addr,
   input  wire logic [COUNT_BITS-1:0]       cnt_wdata,
   output logic      [COUNT_BITS-1:0]       cnt_rdata,
   input  wire logic [$clog2(LEVELS)-1:0]   wt_addr,
   input  wire logic [WEIGHT_BITS-1:0]      wt_wdata,
   output logic      [WEIGHT_BITS-1:0]      wt_rdata
);

   logic [COUNT_BITS-1:0]  cnt_mem [LEVELS];
   logic [WEIGHT_BITS-1:0] wt_mem  [LEVELS];

   logic [LEVELS-1:0]      cnt_vld_ff, cnt_vld_in;
   logic [LEVELS-1:0]      wt_vld_ff,  wt_vld_in;
   logic [COUNT_BITS-1:0]  cnt_q_ff;
   logic [WEIGHT_BITS-1:0] wt_q_ff;
   logic                   cnt_vq_ff;
   logic                   wt_vq_ff;

   always_comb begin
      cnt_vld_in = cnt_vld_ff;
      wt_vld_in  = wt_vld_ff;
      if (cmd.cnt_clr) begin
         cnt_vld_in = '0;
      end else if (cmd.cnt_we) begin
         cnt_vld_in[cnt_addr] = 1'b1;
      end
      if (cmd.wt_we) begin
         wt_vld_in[wt_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         wt_vld_ff  <= '0;
      end else begin
         cnt_vld_ff <= cnt_vld_in;
         wt_vld_ff  <= wt_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_we) begin
         cnt_mem[cnt_addr] <= cnt_wdata;
      end
      cnt_q_ff  <= cnt_mem[cnt_addr];
      cnt_vq_ff <= cnt_vld_ff[cnt_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wt_we) begin
         wt_mem[wt_addr] <= wt_wdata;
      end
      wt_q_ff  <= wt_mem[wt_addr];
      wt_vq_ff <= wt_vld_ff[wt_addr];
   end

   assign cnt_rdata = cnt_vq_ff ? cnt_q_ff : '0;
   assign wt_rdata  = wt_vq_ff  ? wt_q_ff  : '0;

endmodule

`default_nettype wire

[hw/rtl/hmu_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module hmu_mul #(
   parameter int A_BITS = hmu_pkg::WEIGHT_BITS_DEF + 8,
   parameter int B_BITS = hmu_pkg::COUNT_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic [A_BITS-1:0]        op_a,
   input  wire logic [B_BITS-1:0]        op_b,
   output logic      [A_BITS+B_BITS-1:0] prod
);

   logic [A_BITS+B_BITS-1:0] prod_ff;
   logic [A_BITS+B_BITS-1:0] prod_in;

   assign prod_in = (A_BITS+B_BITS)'(op_a) * (A_BITS+B_BITS)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire
